>>> src/mcs51_move_add_execute_macros.svh
// Assertion helpers shared by the checking code of the execute block.
`ifndef MCS51_MOVE_ADD_EXECUTE_MACROS_SVH
`define MCS51_MOVE_ADD_EXECUTE_MACROS_SVH

`define MA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define MA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/mcs51_ma_pkg.sv
package mcs51_ma_pkg;

	typedef logic [4:0] op_class_t;

	localparam op_class_t C_NOP         = 5'd0;
	localparam op_class_t C_MOV_A_RN    = 5'd1;
	localparam op_class_t C_MOV_RN_A    = 5'd2;
	localparam op_class_t C_MOV_RN_DIR  = 5'd3;
	localparam op_class_t C_MOV_RN_IMM  = 5'd4;
	localparam op_class_t C_MOV_DIR_RN  = 5'd5;
	localparam op_class_t C_XCH_RN      = 5'd6;
	localparam op_class_t C_ADD_RN      = 5'd7;
	localparam op_class_t C_MOV_A_DIR   = 5'd8;
	localparam op_class_t C_MOV_A_RI    = 5'd9;
	localparam op_class_t C_MOV_A_IMM   = 5'd10;
	localparam op_class_t C_MOV_DIR_A   = 5'd11;
	localparam op_class_t C_MOV_DIR_DIR = 5'd12;
	localparam op_class_t C_MOV_DIR_RI  = 5'd13;
	localparam op_class_t C_MOV_DIR_IMM = 5'd14;
	localparam op_class_t C_MOV_RI_A    = 5'd15;
	localparam op_class_t C_MOV_RI_DIR  = 5'd16;
	localparam op_class_t C_MOV_RI_IMM  = 5'd17;
	localparam op_class_t C_MOV_DPTR    = 5'd18;
	localparam op_class_t C_MOVX_A_RI   = 5'd19;
	localparam op_class_t C_MOVX_A_DP   = 5'd20;
	localparam op_class_t C_MOVX_RI_A   = 5'd21;
	localparam op_class_t C_MOVX_DP_A   = 5'd22;
	localparam op_class_t C_PUSH        = 5'd23;
	localparam op_class_t C_POP         = 5'd24;
	localparam op_class_t C_XCH_DIR     = 5'd25;
	localparam op_class_t C_XCH_RI      = 5'd26;
	localparam op_class_t C_XCHD        = 5'd27;
	localparam op_class_t C_ADD_DIR     = 5'd28;
	localparam op_class_t C_UNSUP       = 5'd29;

	localparam logic [7:0] SP_RESET = 8'h07;

	typedef struct packed {
		op_class_t   cls;
		logic        uses_ri;
		logic        ri_sel;
		logic [2:0]  rn;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [1:0]  len;
		logic        unsup;
	} instr_t;

endpackage

>>> src/mcs51_ma_front.sv
module mcs51_ma_front import mcs51_ma_pkg::*; (
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] req_type,
	input  logic [7:0] first_operand,
	input  logic [7:0] second_operand,
	input  logic       q_full,
	input  logic       clearing,
	output logic       push,
	output instr_t     push_data
);

	op_class_t  cls;
	logic [1:0] len;

	assign in_ready = !q_full && !clearing;
	assign push     = in_valid && in_ready;

	always_comb begin
		cls = C_UNSUP;
		len = 2'd1;
		if (req_type[3]) begin
			unique case (req_type[7:4])
				4'hE: cls = C_MOV_A_RN;
				4'hF: cls = C_MOV_RN_A;
				4'hA: begin cls = C_MOV_RN_DIR; len = 2'd2; end
				4'h7: begin cls = C_MOV_RN_IMM; len = 2'd2; end
				4'h8: begin cls = C_MOV_DIR_RN; len = 2'd2; end
				4'hC: cls = C_XCH_RN;
				4'h2: cls = C_ADD_RN;
				default: cls = C_UNSUP;
			endcase
		end else begin
			unique case (req_type) inside
				8'h00: cls = C_NOP;
				8'hE5: begin cls = C_MOV_A_DIR; len = 2'd2; end
				8'hE6, 8'hE7: cls = C_MOV_A_RI;
				8'h74: begin cls = C_MOV_A_IMM; len = 2'd2; end
				8'hF5: begin cls = C_MOV_DIR_A; len = 2'd2; end
				8'h85: begin cls = C_MOV_DIR_DIR; len = 2'd3; end
				8'h86, 8'h87: begin cls = C_MOV_DIR_RI; len = 2'd2; end
				8'h75: begin cls = C_MOV_DIR_IMM; len = 2'd3; end
				8'hF6, 8'hF7: cls = C_MOV_RI_A;
				8'hA6, 8'hA7: begin cls = C_MOV_RI_DIR; len = 2'd2; end
				8'h76, 8'h77: begin cls = C_MOV_RI_IMM; len = 2'd2; end
				8'h90: begin cls = C_MOV_DPTR; len = 2'd3; end
				8'hE2, 8'hE3: cls = C_MOVX_A_RI;
				8'hE0: cls = C_MOVX_A_DP;
				8'hF2, 8'hF3: cls = C_MOVX_RI_A;
				8'hF0: cls = C_MOVX_DP_A;
				8'hC0: begin cls = C_PUSH; len = 2'd2; end
				8'hD0: begin cls = C_POP; len = 2'd2; end
				8'hC5: begin cls = C_XCH_DIR; len = 2'd2; end
				8'hC6, 8'hC7: cls = C_XCH_RI;
				8'hD6, 8'hD7: cls = C_XCHD;
				8'h25: begin cls = C_ADD_DIR; len = 2'd2; end
				default: cls = C_UNSUP;
			endcase
		end
	end

	always_comb begin
		push_data.cls     = cls;
		push_data.uses_ri = (cls == C_MOV_A_RI) || (cls == C_MOV_DIR_RI) ||
			(cls == C_MOV_RI_A) || (cls == C_MOV_RI_DIR) || (cls == C_MOV_RI_IMM) ||
			(cls == C_MOVX_A_RI) || (cls == C_MOVX_RI_A) || (cls == C_XCH_RI) ||
			(cls == C_XCHD);
		push_data.ri_sel  = req_type[0];
		push_data.rn      = req_type[2:0];
		push_data.b1      = first_operand;
		push_data.b2      = second_operand;
		push_data.len     = len;
		push_data.unsup   = (cls == C_UNSUP);
	end

endmodule

>>> src/mcs51_ma_queue.sv
module mcs51_ma_queue import mcs51_ma_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  instr_t push_data,
	input  logic   pop,
	output logic   full,
	output logic   valid,
	output instr_t head
);

	instr_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= 2'(cnt_q + 2'd1);
			end else if (pop && !push) begin
				cnt_q <= 2'(cnt_q - 2'd1);
			end
		end
	end

endmodule

>>> src/mcs51_ma_back.sv
`include "mcs51_move_add_execute_macros.svh"

module mcs51_ma_back import mcs51_ma_pkg::*; #(
	parameter int EXT_RAM_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  bank,
	input  logic        q_valid,
	input  instr_t      q_data,
	output logic        q_pop,
	output logic        clearing,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  accumulator_value,
	output logic        carry_out,
	output logic        half_carry,
	output logic        signed_overflow,
	output logic        odd_parity,
	output logic [15:0] pointer_value,
	output logic [7:0]  stack_top,
	output logic [1:0]  instr_length,
	output logic        unsupported
);

	localparam int AW = $clog2(EXT_RAM_DEPTH);
	localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(EXT_RAM_DEPTH));

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RI   = 3'd2;
	localparam logic [2:0] ST_EX   = 3'd3;
	localparam logic [2:0] ST_MOD  = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	instr_t        cur_q;
	logic [7:0]    ri_q;

	logic [7:0]    iram_q [256];
	logic [7:0]    iram_rd_q;
	logic [7:0]    xram_q [EXT_RAM_DEPTH];
	logic [7:0]    xram_rd_q;

	logic [7:0]    acc_q;
	logic          cy_q;
	logic          ac_q;
	logic          ov_q;
	logic          p_q;
	logic [15:0]   dptr_q;
	logic [AW-1:0] dptr_idx_q;
	logic [7:0]    sp_q;
	logic [1:0]    len_q;
	logic          unsup_q;
	logic          out_valid_q;

	logic [15:0]   rem_q;
	logic [15:0]   quo_q;
	logic [1:0]    mod_k_q;
	logic [47:0]   mod_prod;
	logic [32:0]   mod_qd;
	logic [16:0]   mod_r1;
	logic [16:0]   mod_red;

	instr_t        src;
	logic          take;
	logic          rd_en;
	logic [7:0]    iram_ra;
	logic [AW-1:0] xram_ra;
	logic          ex_go;
	logic          ex_next_ok;

	logic          ex_iwe;
	logic [7:0]    ex_iwa;
	logic [7:0]    ex_iwd;
	logic          ex_xwe;
	logic [AW-1:0] ex_xwa;
	logic [7:0]    acc_n;
	logic [7:0]    sp_n;
	logic [15:0]   dptr_n;
	logic          add_en;
	logic [8:0]    sum7;
	logic [4:0]    sum3;
	logic [7:0]    sum6;

	logic          iwe;
	logic [7:0]    iwa;
	logic [7:0]    iwd;
	logic          xwe;
	logic [AW-1:0] xwa;
	logic [7:0]    xwd;

	assign take     = (state_q == ST_IDLE) && q_valid;
	assign q_pop    = take;
	assign clearing = (state_q == ST_CLR);
	assign src      = (state_q == ST_IDLE) ? q_data : cur_q;
	assign rd_en    = take || (state_q == ST_RI);
	assign ex_go    = (state_q == ST_EX) && (!out_valid_q || out_ready);
	assign ex_next_ok = out_valid_q && (state_q == ST_IDLE || state_q == ST_MOD);

	always_comb begin
		iram_ra = src.b1;
		xram_ra = dptr_idx_q;
		if (state_q == ST_RI) begin
			iram_ra = (src.cls == C_MOV_RI_DIR) ? src.b1 : iram_rd_q;
			xram_ra = AW'(iram_rd_q);
		end else if (src.uses_ri) begin
			iram_ra = {3'b000, bank, 2'b00, src.ri_sel};
		end else begin
			case (src.cls)
				C_MOV_A_RN, C_MOV_DIR_RN, C_XCH_RN, C_ADD_RN: iram_ra = {3'b000, bank, src.rn};
				C_POP: iram_ra = sp_q;
				default: iram_ra = src.b1;
			endcase
		end
	end

	assign sum7 = {1'b0, acc_q} + {1'b0, iram_rd_q};
	assign sum3 = {1'b0, acc_q[3:0]} + {1'b0, iram_rd_q[3:0]};
	assign sum6 = {1'b0, acc_q[6:0]} + {1'b0, iram_rd_q[6:0]};

	always_comb begin
		ex_iwe = 1'b0;
		ex_iwa = {3'b000, bank, cur_q.rn};
		ex_iwd = acc_q;
		ex_xwe = 1'b0;
		ex_xwa = dptr_idx_q;
		acc_n  = acc_q;
		sp_n   = sp_q;
		dptr_n = dptr_q;
		add_en = 1'b0;
		case (cur_q.cls)
			C_MOV_A_RN, C_MOV_A_DIR, C_MOV_A_RI: acc_n = iram_rd_q;
			C_MOV_RN_A: ex_iwe = 1'b1;
			C_MOV_RN_DIR: begin ex_iwe = 1'b1; ex_iwd = iram_rd_q; end
			C_MOV_RN_IMM: begin ex_iwe = 1'b1; ex_iwd = cur_q.b1; end
			C_MOV_DIR_RN, C_MOV_DIR_RI, C_POP: begin
				ex_iwe = 1'b1;
				ex_iwa = cur_q.b1;
				ex_iwd = iram_rd_q;
				if (cur_q.cls == C_POP) begin
					sp_n = 8'(sp_q - 8'd1);
				end
			end
			C_XCH_RN: begin ex_iwe = 1'b1; acc_n = iram_rd_q; end
			C_ADD_RN, C_ADD_DIR: begin add_en = 1'b1; acc_n = sum7[7:0]; end
			C_MOV_A_IMM: acc_n = cur_q.b1;
			C_MOV_DIR_A: begin ex_iwe = 1'b1; ex_iwa = cur_q.b1; end
			C_MOV_DIR_DIR: begin ex_iwe = 1'b1; ex_iwa = cur_q.b2; ex_iwd = iram_rd_q; end
			C_MOV_DIR_IMM: begin ex_iwe = 1'b1; ex_iwa = cur_q.b1; ex_iwd = cur_q.b2; end
			C_MOV_RI_A: begin ex_iwe = 1'b1; ex_iwa = ri_q; end
			C_MOV_RI_DIR: begin ex_iwe = 1'b1; ex_iwa = ri_q; ex_iwd = iram_rd_q; end
			C_MOV_RI_IMM: begin ex_iwe = 1'b1; ex_iwa = ri_q; ex_iwd = cur_q.b1; end
			C_MOV_DPTR: dptr_n = {cur_q.b1, cur_q.b2};
			C_MOVX_A_RI, C_MOVX_A_DP: acc_n = xram_rd_q;
			C_MOVX_RI_A: begin ex_xwe = 1'b1; ex_xwa = AW'(ri_q); end
			C_MOVX_DP_A: ex_xwe = 1'b1;
			C_PUSH: begin
				sp_n   = 8'(sp_q + 8'd1);
				ex_iwe = 1'b1;
				ex_iwa = 8'(sp_q + 8'd1);
				ex_iwd = iram_rd_q;
			end
			C_XCH_DIR: begin ex_iwe = 1'b1; ex_iwa = cur_q.b1; acc_n = iram_rd_q; end
			C_XCH_RI: begin ex_iwe = 1'b1; ex_iwa = ri_q; acc_n = iram_rd_q; end
			C_XCHD: begin
				ex_iwe = 1'b1;
				ex_iwa = ri_q;
				ex_iwd = {iram_rd_q[7:4], acc_q[3:0]};
				acc_n  = {acc_q[7:4], iram_rd_q[3:0]};
			end
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == ST_CLR) begin
			iwe = 1'b1;
			iwa = clr_q[7:0];
			iwd = 8'h00;
			xwe = 1'b1;
			xwa = clr_q;
			xwd = 8'h00;
		end else begin
			iwe = ex_go && ex_iwe;
			iwa = ex_iwa;
			iwd = ex_iwd;
			xwe = ex_go && ex_xwe;
			xwa = ex_xwa;
			xwd = acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (iwe) begin
			iram_q[iwa] <= iwd;
		end
		if (rd_en) begin
			iram_rd_q <= iram_q[iram_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (xwe) begin
			xram_q[xwa] <= xwd;
		end
		if (rd_en) begin
			xram_rd_q <= xram_q[xram_ra];
		end
	end

	// DPTR is reduced modulo the external RAM depth by a reciprocal multiplication, which
	// leaves the quotient at most one short, and a single correcting subtraction.
	assign mod_prod = 48'(rem_q) * 48'(RECIP);
	assign mod_qd   = 33'(quo_q) * 33'(EXT_RAM_DEPTH);
	assign mod_r1   = {1'b0, rem_q} - mod_qd[16:0];
	assign mod_red  = ({1'b0, rem_q} >= 17'(EXT_RAM_DEPTH)) ?
		17'({1'b0, rem_q} - 17'(EXT_RAM_DEPTH)) : {1'b0, rem_q};

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= q_data;
		end
		if (state_q == ST_RI) begin
			ri_q <= iram_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			acc_q       <= 8'h00;
			cy_q        <= 1'b0;
			ac_q        <= 1'b0;
			ov_q        <= 1'b0;
			p_q         <= 1'b0;
			dptr_q      <= 16'h0000;
			dptr_idx_q  <= '0;
			sp_q        <= SP_RESET;
			len_q       <= 2'd1;
			unsup_q     <= 1'b0;
			out_valid_q <= 1'b0;
			rem_q       <= 16'h0000;
			quo_q       <= 16'h0000;
			mod_k_q     <= 2'd0;
		end else begin
			if (out_ready && !ex_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= AW'(clr_q + 1'b1);
					if (clr_q == AW'(EXT_RAM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						state_q <= q_data.uses_ri ? ST_RI : ST_EX;
					end
				end
				ST_RI: state_q <= ST_EX;
				ST_EX: begin
					if (ex_go) begin
						out_valid_q <= 1'b1;
						acc_q       <= acc_n;
						sp_q        <= sp_n;
						dptr_q      <= dptr_n;
						len_q       <= cur_q.len;
						unsup_q     <= cur_q.unsup;
						if (!cur_q.unsup) begin
							p_q <= ^acc_n;
						end
						if (add_en) begin
							cy_q <= sum7[8];
							ac_q <= sum3[4];
							ov_q <= sum6[7] ^ sum7[8];
						end
						if (cur_q.cls == C_MOV_DPTR) begin
							rem_q   <= dptr_n;
							mod_k_q <= 2'd0;
							state_q <= ST_MOD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_MOD: begin
					mod_k_q <= 2'(mod_k_q + 2'd1);
					if (mod_k_q == 2'd0) begin
						quo_q <= mod_prod[47:32];
					end else if (mod_k_q == 2'd1) begin
						rem_q <= mod_r1[15:0];
					end else begin
						dptr_idx_q <= mod_red[AW-1:0];
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign accumulator_value = acc_q;
	assign carry_out         = cy_q;
	assign half_carry        = ac_q;
	assign signed_overflow   = ov_q;
	assign odd_parity        = p_q;
	assign pointer_value     = dptr_q;
	assign stack_top         = sp_q;
	assign instr_length      = len_q;
	assign unsupported       = unsup_q;

	`MA_ASSERT_IMPL(a_no_result_in_clear, clk, arst_n, state_q == ST_CLR, !out_valid_q, "result during clear")
	`MA_ASSERT_NEXT(a_ex_hands_over, clk, arst_n, ex_go, ex_next_ok, "execute did not complete")
	`MA_ASSERT_IMPL(a_no_pop_in_mod, clk, arst_n, state_q == ST_MOD || state_q == ST_RI, !q_pop, "pop while busy")

endmodule

>>> src/mcs51_move_add_execute.sv
// Executes one pre-fetched 8051 move, exchange, stack or ADD instruction per input transaction
// and returns one result transaction with the accumulator, flags, DPTR, SP, instruction length
// and an unsupported flag. After reset the block steps through the external RAM depth to clear
// both RAMs and accepts no transaction until that pass ends; configuration writes are taken
// throughout. A decoder and a two-entry queue take instructions while the executor works; the
// executor reads the internal RAM through a registered read before its write, the @Ri forms
// first read the pointer register, and MOV DPTR,#data adds a reduction of DPTR to an external
// RAM address; the next instruction is taken only after the last one is done.
module mcs51_move_add_execute import mcs51_ma_pkg::*; #(
	parameter int EXT_RAM_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  req_type,
	input  logic [7:0]  first_operand,
	input  logic [7:0]  second_operand,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  accumulator_value,
	output logic        carry_out,
	output logic        half_carry,
	output logic        signed_overflow,
	output logic        odd_parity,
	output logic [15:0] pointer_value,
	output logic [7:0]  stack_top,
	output logic [1:0]  instr_length,
	output logic        unsupported
);

	logic [1:0] bank_q;
	logic       q_full;
	logic       q_valid;
	logic       push;
	logic       pop;
	logic       clearing;
	instr_t     push_data;
	instr_t     head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 2'd0;
		end else if (cfg_wr_en) begin
			bank_q <= cfg_wr_data;
		end
	end

	mcs51_ma_front u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.q_full         (q_full),
		.clearing       (clearing),
		.push           (push),
		.push_data      (push_data)
	);

	mcs51_ma_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.valid     (q_valid),
		.head      (head)
	);

	mcs51_ma_back #(
		.EXT_RAM_DEPTH (EXT_RAM_DEPTH)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.bank              (bank_q),
		.q_valid           (q_valid),
		.q_data            (head),
		.q_pop             (pop),
		.clearing          (clearing),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.accumulator_value (accumulator_value),
		.carry_out         (carry_out),
		.half_carry        (half_carry),
		.signed_overflow   (signed_overflow),
		.odd_parity        (odd_parity),
		.pointer_value     (pointer_value),
		.stack_top         (stack_top),
		.instr_length      (instr_length),
		.unsupported       (unsupported)
	);

endmodule
